// ----- sv/pid_pkg.sv -----
// Package: shared item type and status codes for the prefixed integer decoder.
`timescale 1ns / 1ps

package pid_pkg;

    typedef enum logic [1:0] {
        STATUS_MORE = 2'd0,
        STATUS_DONE = 2'd1,
        STATUS_ERR  = 2'd2
    } pid_status_t;

    // One classified request as it travels from front to back.
    typedef struct packed {
        logic       start;  // prefix byte of a new integer
        logic       last;   // start: prefix not all ones; continuation: top bit clear
        logic [7:0] val;    // start: masked prefix; continuation: low 7 bits
    } pid_item_t;

    localparam int PREFIX_MAX_BITS = 8;
    localparam int CONT_BITS       = 7;
    localparam int SHIFT_W         = 7;
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 7'd62;
    localparam int VALUE_W         = 62;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = 1;
    localparam int QCNT_W          = 2;

endpackage

// ----- sv/pid_front.sv -----
// Front end: takes input requests, masks the prefix and tags each byte.
`timescale 1ns / 1ps

module pid_front
    import pid_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       start_req,
    input  logic [3:0] prefix_bits,
    input  logic       q_full,
    output logic       q_push,
    output pid_item_t  q_item
);

    logic [3:0] pw;
    logic [8:0] k_wide;
    logic [7:0] k;
    logic [7:0] masked;

    always_comb
    begin
        if (prefix_bits == 4'd0 || prefix_bits > 4'(PREFIX_MAX_BITS))
        begin
            pw = 4'(PREFIX_MAX_BITS);
        end
        else
        begin
            pw = prefix_bits;
        end
        k_wide = (9'd1 << pw) - 9'd1;
        k      = k_wide[7:0];
        masked = data_byte & k;

        q_item.start = start_req;
        if (start_req)
        begin
            q_item.last = (masked != k);
            q_item.val  = masked;
        end
        else
        begin
            q_item.last = ~data_byte[7];
            q_item.val  = {1'b0, data_byte[CONT_BITS-1:0]};
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid & ~q_full;

endmodule

// ----- sv/pid_queue.sv -----
// Two-entry queue between the front end and the accumulator.
`timescale 1ns / 1ps

module pid_queue
    import pid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pid_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output pid_item_t pop_item
);

    pid_item_t          store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

// ----- sv/pid_back.sv -----
// Back end: accumulates continuation bytes, checks limits, holds the result register.
`timescale 1ns / 1ps

module pid_back
    import pid_pkg::*;
#(
    parameter int VALUE_LIMIT_BITS = 62
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  pid_item_t          q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [VALUE_W-1:0] value
);

    localparam int AW = VALUE_LIMIT_BITS;
    localparam int SW = 64 + CONT_BITS - 1;
    localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_LIMIT_BITS) - 64'd1;

    logic [AW-1:0]      acc_reg, acc_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic               failed_reg, failed_next;
    logic               busy_reg, busy_next;
    logic               out_valid_reg, out_valid_next;
    pid_status_t        status_reg, status_next;
    logic [VALUE_W-1:0] value_reg;

    logic [SW-1:0]      shifted;
    logic [63:0]        sum;
    logic [63:0]        acc_new64;

    assign q_pop = q_not_empty & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        shifted = SW'(q_item.val[CONT_BITS-1:0]) << shift_reg[5:0];
        sum     = 64'(acc_reg) + shifted[63:0];

        acc_next    = acc_reg;
        shift_next  = shift_reg;
        failed_next = failed_reg;
        busy_next   = busy_reg;
        status_next = STATUS_ERR;

        priority if (q_item.start)
        begin
            acc_next    = AW'(q_item.val);
            shift_next  = '0;
            failed_next = 1'b0;
            busy_next   = ~q_item.last;
            status_next = q_item.last ? STATUS_DONE : STATUS_MORE;
        end
        else if (failed_reg)
        begin
            status_next = STATUS_ERR;
        end
        else if (!busy_reg || shift_reg > SHIFT_LIMIT
                 || shifted > SW'(VALUE_MAX) || sum > VALUE_MAX)
        begin
            failed_next = 1'b1;
            busy_next   = 1'b0;
            status_next = STATUS_ERR;
        end
        else
        begin
            acc_next = sum[AW-1:0];
            if (q_item.last)
            begin
                busy_next   = 1'b0;
                status_next = STATUS_DONE;
            end
            else
            begin
                shift_next  = shift_reg + SHIFT_W'(CONT_BITS);
                status_next = STATUS_MORE;
            end
        end

        acc_new64 = 64'(acc_next);

        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            shift_reg     <= '0;
            failed_reg    <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                acc_reg    <= acc_next;
                shift_reg  <= shift_next;
                failed_reg <= failed_next;
                busy_reg   <= busy_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= status_next;
            value_reg  <= acc_new64[VALUE_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;

    a_fail_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> !busy_reg)
        else $error("error flag set while integer in progress");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        shift_reg <= SHIFT_LIMIT + SHIFT_W'(CONT_BITS))
        else $error("shift count out of range");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_item.start |=> !failed_reg && shift_reg == '0)
        else $error("start request did not clear state");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && !q_item.start && failed_reg |=> failed_reg && status_reg == STATUS_ERR)
        else $error("sticky error lost");

endmodule

// ----- sv/prefixed_integer_decoder.sv -----
// Top level: prefixed integer decoder (front end, queue, accumulator).
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, data_byte,           | into block
//          | start_req, prefix_bits                   |
//  out     | out_valid, out_stall, status, value      | out of block
//
// One request per cycle sustained while the output is not stalled; each request yields one result.
// An accepted request is written into the queue, then popped into the result registers.
// The accumulator's shift, compare and 64-bit add set the per-cycle path.
// Reset clears the accumulator, shift count, error flag and queue; no clearing pass.
// A stalled output backs up the two-entry queue, then stalls the input.
`timescale 1ns / 1ps

module prefixed_integer_decoder
    import pid_pkg::*;
#(
    parameter int VALUE_LIMIT_BITS = 62
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               start_req,
    input  logic [3:0]         prefix_bits,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [VALUE_W-1:0] value
);

    logic      q_full;
    logic      q_push;
    pid_item_t q_in_item;
    logic      q_not_empty;
    logic      q_pop;
    pid_item_t q_out_item;

    pid_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .start_req   (start_req),
        .prefix_bits (prefix_bits),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_in_item)
    );

    pid_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_out_item)
    );

    pid_back #(
        .VALUE_LIMIT_BITS (VALUE_LIMIT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_item      (q_out_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .value       (value)
    );

endmodule

// ----- dv/tb.sv -----
// Testbench for the prefixed integer decoder: directed table, random streams, predictor.
`timescale 1ns / 1ps

module tb;
    import pid_pkg::*;

    localparam int LIMIT_BITS  = 62;
    localparam int ITEMS_TOTAL = 1150;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 10;
    localparam int MAX_REPORTS = 10;
    localparam logic [63:0] VALUE_CEIL = (64'd1 << LIMIT_BITS) - 64'd1;

    typedef struct packed {
        pid_status_t        status;
        logic [VALUE_W-1:0] value;
    } decode_result_t;

    // One directed request; typed marks rows whose result is written out here.
    typedef struct packed {
        logic [7:0]         data;
        logic               start;
        logic [3:0]         pbits;
        logic               typed;
        pid_status_t        status;
        logic [VALUE_W-1:0] value;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{8'h00, 1'b0, 4'd0,  1'b1, STATUS_ERR,  62'd0},   // stray byte after reset
        '{8'h7f, 1'b0, 4'd3,  1'b1, STATUS_ERR,  62'd0},   // error holds
        '{8'he3, 1'b1, 4'd5,  1'b1, STATUS_DONE, 62'd3},
        '{8'hff, 1'b1, 4'd0,  1'b1, STATUS_MORE, 62'd255},
        '{8'h80, 1'b0, 4'd15, 1'b0, STATUS_MORE, 62'd0},   // walk the shift up to 63
        '{8'h80, 1'b0, 4'd1,  1'b0, STATUS_MORE, 62'd0},
        '{8'h80, 1'b0, 4'd8,  1'b0, STATUS_MORE, 62'd0},
        '{8'h80, 1'b0, 4'd0,  1'b0, STATUS_MORE, 62'd0},
        '{8'h80, 1'b0, 4'd12, 1'b0, STATUS_MORE, 62'd0},
        '{8'h80, 1'b0, 4'd4,  1'b0, STATUS_MORE, 62'd0},
        '{8'h80, 1'b0, 4'd2,  1'b0, STATUS_MORE, 62'd0},
        '{8'h80, 1'b0, 4'd7,  1'b0, STATUS_MORE, 62'd0},
        '{8'h80, 1'b0, 4'd9,  1'b0, STATUS_MORE, 62'd0},
        '{8'h81, 1'b0, 4'd0,  1'b1, STATUS_ERR,  62'd255}, // shift past 62
        '{8'h00, 1'b0, 4'd0,  1'b1, STATUS_ERR,  62'd255},
        '{8'hfe, 1'b1, 4'd9,  1'b1, STATUS_DONE, 62'd254}, // width above 8
        '{8'h05, 1'b0, 4'd0,  1'b1, STATUS_ERR,  62'd254}, // stray after completion
        '{8'h01, 1'b1, 4'd1,  1'b1, STATUS_MORE, 62'd1},
        '{8'hff, 1'b0, 4'd2,  1'b0, STATUS_MORE, 62'd0},
        '{8'h7f, 1'b0, 4'd0,  1'b0, STATUS_MORE, 62'd0},
        '{8'h00, 1'b1, 4'd15, 1'b1, STATUS_DONE, 62'd0},
        '{8'hff, 1'b1, 4'd2,  1'b1, STATUS_MORE, 62'd3},
        '{8'h7f, 1'b0, 4'd0,  1'b0, STATUS_MORE, 62'd0},
        '{8'h7f, 1'b1, 4'd0,  1'b1, STATUS_DONE, 62'd127},
        '{8'h7f, 1'b1, 4'd7,  1'b1, STATUS_MORE, 62'd127}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         data_byte;
    logic               start_req;
    logic [3:0]         prefix_bits;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [VALUE_W-1:0] value;

    // predictor state
    logic [VALUE_W-1:0] acc_q;
    logic [SHIFT_W-1:0] shift_q;
    logic               err_q;
    logic               busy_q;

    decode_result_t pending_results[$];
    int             mismatch_count = 0;
    int             accepted_count = 0;
    bit             no_idle = 1'b0;
    bit             hold_req = 1'b0;

    prefixed_integer_decoder #(
        .VALUE_LIMIT_BITS(LIMIT_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .start_req   (start_req),
        .prefix_bits (prefix_bits),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .value       (value)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic decode_result_t decode_byte(input logic [7:0] b, input logic st,
                                                   input logic [3:0] pb);
        decode_result_t r;
        logic [7:0]     mask;
        logic [63:0]    add;
        int             width;
        r.status = STATUS_MORE;
        if (st)
        begin
            width = (pb == 4'd0 || pb > PREFIX_MAX_BITS) ? PREFIX_MAX_BITS : int'(pb);
            mask = 8'hff >> (PREFIX_MAX_BITS - width);
            err_q = 1'b0;
            shift_q = '0;
            busy_q = ((b & mask) == mask);
            acc_q = VALUE_W'(b & mask);
            r.status = busy_q ? STATUS_MORE : STATUS_DONE;
        end
        else if (err_q)
        begin
            r.status = STATUS_ERR;
        end
        else
        begin
            add = 64'(b[6:0]);
            // no integer open, shift too far, digit too big, or sum over the limit
            if (!busy_q || shift_q > SHIFT_LIMIT || (VALUE_CEIL >> shift_q) < add
                || VALUE_CEIL - (add << shift_q) < 64'(acc_q))
            begin
                err_q = 1'b1;
                busy_q = 1'b0;
                r.status = STATUS_ERR;
            end
            else
            begin
                acc_q = acc_q + VALUE_W'(add << shift_q);
                if (b[7])
                begin
                    shift_q = shift_q + SHIFT_W'(CONT_BITS);
                    r.status = STATUS_MORE;
                end
                else
                begin
                    busy_q = 1'b0;
                    r.status = STATUS_DONE;
                end
            end
        end
        r.value = acc_q;
        return r;
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Offer one request, wait for it to be taken, queue what it should produce.
    task automatic send_request(input logic [7:0] b, input logic st, input logic [3:0] pb,
                                input logic typed, input decode_result_t fixed);
        int             gap;
        decode_result_t r;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        start_req   <= st;
        prefix_bits <= pb;
        do @(posedge clk); while (in_stall);
        r = decode_byte(b, st, pb);
        pending_results.push_back(typed ? fixed : r);
        accepted_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic st, input logic [3:0] pb);
        send_request(b, st, pb, 1'b0, '0);
    endtask

    task automatic drain_pause();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // A prefix byte and, when the prefix is all ones, a run of continuation bytes.
    task automatic send_integer();
        logic [3:0] pb;
        logic [7:0] b;
        logic [7:0] mask;
        logic [6:0] digit;
        logic       top;
        int         width;
        int         n;
        bit         saturate;
        pb = 4'($urandom_range(0, 15));
        width = (pb == 4'd0 || pb > PREFIX_MAX_BITS) ? PREFIX_MAX_BITS : int'(pb);
        mask = 8'hff >> (PREFIX_MAX_BITS - width);
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0)
            b = b | mask;
        send_byte(b, 1'b1, pb);
        if ((b & mask) != mask)
            return;
        saturate = 1'b0;
        if ($urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(8, 11);
            saturate = $urandom_range(0, 1);
        end
        else
        begin
            n = $urandom_range(1, 4);
        end
        for (int i = 1; i <= n; i++)
        begin
            case ($urandom_range(0, 7))
                0, 1, 2: digit = 7'h7f;
                3:       digit = 7'h00;
                4:       digit = 7'h3f;
                5:       digit = 7'h40;
                default: digit = 7'($urandom_range(0, 127));
            endcase
            // fill the low digits so the byte at shift 56 lands on the limit
            if (saturate && i < 9)
                digit = 7'h7f;
            top = (i < n) ? 1'b1 : ($urandom_range(0, 9) == 0);
            send_byte({top, digit}, 1'b0, 4'($urandom_range(0, 15)));
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                      4'($urandom_range(0, 15)));
    endtask

    // result side: random stalls, plus one long hold on request
    initial
    begin
        int w;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_req)
            begin
                hold_req = 1'b0;
                w = HOLD_CYCLES;
            end
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        decode_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result: status %0d value %0d",
                                        status, value));
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || value !== want.value)
                    flag_mismatch($sformatf(
                        "result mismatch: status exp %0d got %0d, value exp %0d got %0d",
                        want.status, status, want.value, value));
            end
        end
    end

    initial
    begin
        int             seq_no;
        decode_result_t fixed;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        data_byte   <= '0;
        start_req   <= 1'b0;
        prefix_bits <= '0;
        acc_q   = '0;
        shift_q = '0;
        err_q   = 1'b0;
        busy_q  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            fixed.status = DIRECTED[i].status;
            fixed.value  = DIRECTED[i].value;
            send_request(DIRECTED[i].data, DIRECTED[i].start, DIRECTED[i].pbits,
                         DIRECTED[i].typed, fixed);
        end

        seq_no = 0;
        while (accepted_count < ITEMS_TOTAL)
        begin
            seq_no++;
            no_idle = ((seq_no / 25) % 4 == 3);
            if (seq_no == 40 || seq_no == 170)
                hold_req = 1'b1;
            if (seq_no == 90 || seq_no == 220)
                drain_pause();
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_integer();
        end

        drain_pause();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/pid_pkg.sv
sv/pid_front.sv
sv/pid_queue.sv
sv/pid_back.sv
sv/prefixed_integer_decoder.sv
dv/tb.sv
